// ===== sv/rslc_pkg.sv =====
// Package for the RGB status LED controller: command, mode, alert and colour codes,
// the colour decode table and the structure shared between the modules.
// No dependencies.
`timescale 1ns / 1ps

package rslc_pkg;

    // Default timing of the blink and flash patterns, in ticks.
    localparam int ON_TICKS_DEF  = 100;
    localparam int OFF_TICKS_DEF = 100;

    // Field and storage widths.
    localparam int NUM_ENTRIES = 7;
    localparam int ENTRY_W     = 11;
    localparam int INT_W       = 8;
    localparam int LEVEL_W     = 8;
    localparam int LEVELS_W    = 3 * LEVEL_W;
    localparam int CODE_W      = 3;
    localparam int KIND_W      = 4;
    localparam int VALUE_W     = 8;
    localparam int COUNT_W     = 16;
    localparam int CNT_EXT_W   = COUNT_W + 1;
    localparam int DUTY_W      = 14;
    localparam int IDX_W       = 3;

    // Entry positions in the configuration register list.
    localparam logic [IDX_W-1:0] ENT_ALERT        = 3'd0;
    localparam logic [IDX_W-1:0] ENT_BLINK        = 3'd1;
    localparam logic [IDX_W-1:0] ENT_FEEDBACK     = 3'd2;
    localparam logic [IDX_W-1:0] ENT_IDLE         = 3'd3;
    localparam logic [IDX_W-1:0] ENT_TOUCH_SHORT  = 3'd4;
    localparam logic [IDX_W-1:0] ENT_TOUCH_DOUBLE = 3'd5;
    localparam logic [IDX_W-1:0] ENT_TOUCH_LONG   = 3'd6;

    // Largest meaningful mode and alert codes.
    localparam logic [VALUE_W-1:0] MODE_MAX  = 8'd5;
    localparam logic [VALUE_W-1:0] ALERT_MAX = 8'd4;

    // Colour channel levels used by the decode table.
    localparam logic [LEVEL_W-1:0] LVL_FULL   = 8'hff;
    localparam logic [LEVEL_W-1:0] LVL_ORANGE = 8'hbf;
    localparam logic [LEVEL_W-1:0] LVL_NONE   = 8'h00;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK      = 4'd0,
        KIND_ENABLE    = 4'd1,
        KIND_DISABLE   = 4'd2,
        KIND_ON        = 4'd3,
        KIND_OFF       = 4'd4,
        KIND_INTENSITY = 4'd5,
        KIND_SHOW      = 4'd6,
        KIND_SET_MODE  = 4'd7,
        KIND_IDLE_SEL  = 4'd8,
        KIND_ALERT     = 4'd9
    } t_kind;

    typedef enum logic [2:0] {
        MODE_BLINK        = 3'd0,
        MODE_IDLE         = 3'd1,
        MODE_TOUCH_SHORT  = 3'd2,
        MODE_TOUCH_DOUBLE = 3'd3,
        MODE_TOUCH_LONG   = 3'd4,
        MODE_OFF          = 3'd5
    } t_mode;

    typedef enum logic [2:0] {
        ALERT_NONE  = 3'd0,
        ALERT_CONT  = 3'd1,
        ALERT_BLINK = 3'd2,
        ALERT_FLASH = 3'd3,
        ALERT_FADE  = 3'd4
    } t_alert;

    typedef enum logic [CODE_W-1:0] {
        COL_RED     = 3'd0,
        COL_GREEN   = 3'd1,
        COL_BLUE    = 3'd2,
        COL_YELLOW  = 3'd3,
        COL_ORANGE  = 3'd4,
        COL_MAGENTA = 3'd5,
        COL_CYAN    = 3'd6,
        COL_WHITE   = 3'd7
    } t_colour;

    typedef enum logic [1:0] {
        WR_NONE      = 2'd0,
        WR_BUFFERED  = 2'd1,
        WR_IMMEDIATE = 2'd2
    } t_written;

    // Request from the command logic to the duty multipliers.
    typedef struct packed {
        logic [LEVELS_W-1:0] levels;
        logic [INT_W-1:0]    intensity;
        logic                zero;
    } t_duty_req;

    // Colour code to packed levels: red in the top byte, blue in the bottom.
    function automatic logic [LEVELS_W-1:0] colour_levels(input logic [CODE_W-1:0] code);
        logic [LEVELS_W-1:0] lv;
        case (code)
            COL_RED:     lv = {LVL_FULL, LVL_NONE,   LVL_NONE};
            COL_GREEN:   lv = {LVL_NONE, LVL_FULL,   LVL_NONE};
            COL_BLUE:    lv = {LVL_NONE, LVL_NONE,   LVL_FULL};
            COL_YELLOW:  lv = {LVL_FULL, LVL_FULL,   LVL_NONE};
            COL_ORANGE:  lv = {LVL_FULL, LVL_ORANGE, LVL_NONE};
            COL_MAGENTA: lv = {LVL_FULL, LVL_NONE,   LVL_FULL};
            COL_CYAN:    lv = {LVL_NONE, LVL_FULL,   LVL_FULL};
            default:     lv = {LVL_FULL, LVL_FULL,   LVL_FULL};
        endcase
        return lv;
    endfunction

endpackage

// ===== sv/rslc_duty.sv =====
// Duty calculation for the three PWM channels: level times intensity, over four.
// Depends on rslc_pkg.
`timescale 1ns / 1ps

module rslc_duty import rslc_pkg::*; (
    input  t_duty_req          i_req,
    output logic [DUTY_W-1:0]  o_red_duty,
    output logic [DUTY_W-1:0]  o_green_duty,
    output logic [DUTY_W-1:0]  o_blue_duty
);

    logic [2*LEVEL_W-1:0] w_red_prod;
    logic [2*LEVEL_W-1:0] w_green_prod;
    logic [2*LEVEL_W-1:0] w_blue_prod;

    // One 8 by 8 multiplier per channel.
    assign w_red_prod   = i_req.levels[3*LEVEL_W-1:2*LEVEL_W] * i_req.intensity;
    assign w_green_prod = i_req.levels[2*LEVEL_W-1:LEVEL_W]   * i_req.intensity;
    assign w_blue_prod  = i_req.levels[LEVEL_W-1:0]           * i_req.intensity;

    // Drop the two low bits; a zero request forces all channels off.
    assign o_red_duty   = i_req.zero ? '0 : w_red_prod[2*LEVEL_W-1:2];
    assign o_green_duty = i_req.zero ? '0 : w_green_prod[2*LEVEL_W-1:2];
    assign o_blue_duty  = i_req.zero ? '0 : w_blue_prod[2*LEVEL_W-1:2];

endmodule

// ===== sv/rslc_core.sv =====
// Command and tick handling of the status LED controller: holds the enable,
// mode, alert, colour and blink counter state and decides each duty write.
// Depends on rslc_pkg.
`timescale 1ns / 1ps

module rslc_core import rslc_pkg::*; #(
    parameter int ON_TICKS  = ON_TICKS_DEF,
    parameter int OFF_TICKS = OFF_TICKS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_advance,
    input  logic [KIND_W-1:0]                    i_kind,
    input  logic [VALUE_W-1:0]                   i_value,
    input  logic [CODE_W-1:0]                    i_color,
    input  logic [NUM_ENTRIES-1:0][ENTRY_W-1:0]  i_entries,
    output t_duty_req                            o_req,
    output t_written                             o_written,
    output logic                                 o_status
);

    localparam logic signed [CNT_EXT_W-1:0] ON_LIMIT  = CNT_EXT_W'(ON_TICKS);
    localparam logic signed [CNT_EXT_W-1:0] OFF_LIMIT = -CNT_EXT_W'(OFF_TICKS);

    logic                 r_enabled,   n_enabled;
    t_mode                r_mode,      n_mode;
    logic                 r_idle_sel,  n_idle_sel;
    t_alert               r_alert,     n_alert;
    logic [INT_W-1:0]     r_intensity, n_intensity;
    logic [LEVELS_W-1:0]  r_levels,    n_levels;
    logic [COUNT_W-1:0]   r_count,     n_count;

    logic signed [CNT_EXT_W-1:0] w_cnt;
    logic signed [CNT_EXT_W-1:0] w_blink_next;
    logic [1:0]                  w_step;
    logic                        w_run_blink;
    logic                        w_show;
    logic                        w_from_entry;
    logic [IDX_W-1:0]            w_idx;
    logic [ENTRY_W-1:0]          w_entry;
    logic [CODE_W-1:0]           w_code;
    logic [INT_W-1:0]            w_int;
    logic                        w_update;
    logic                        w_zero_write;

    // State registers advance only when the item moves to the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled   <= 1'b0;
            r_mode      <= MODE_OFF;
            r_idle_sel  <= 1'b0;
            r_alert     <= ALERT_NONE;
            r_intensity <= '0;
            r_levels    <= '0;
            r_count     <= '0;
        end else if (i_advance) begin
            r_enabled   <= n_enabled;
            r_mode      <= n_mode;
            r_idle_sel  <= n_idle_sel;
            r_alert     <= n_alert;
            r_intensity <= n_intensity;
            r_levels    <= n_levels;
            r_count     <= n_count;
        end
    end

    // Signed view of the counter and its next blink step.
    assign w_cnt        = $signed({r_count[COUNT_W-1], r_count});
    assign w_blink_next = w_cnt[CNT_EXT_W-1] ? (w_cnt - CNT_EXT_W'(1))
                                             : (w_cnt + $signed({{(CNT_EXT_W-2){1'b0}}, w_step}));
    assign w_entry      = i_entries[w_idx];
    assign w_code       = w_from_entry ? w_entry[CODE_W-1:0] : i_color;
    assign w_int        = w_from_entry ? w_entry[ENTRY_W-1:CODE_W] : i_value;

    // Command decode, blink sequencing and duty write selection.
    always_comb begin
        n_enabled    = r_enabled;
        n_mode       = r_mode;
        n_idle_sel   = r_idle_sel;
        n_alert      = r_alert;
        n_intensity  = r_intensity;
        n_levels     = r_levels;
        n_count      = r_count;
        o_written    = WR_NONE;
        o_status     = 1'b0;
        w_step       = 2'd1;
        w_run_blink  = 1'b0;
        w_show       = 1'b0;
        w_from_entry = 1'b1;
        w_idx        = ENT_ALERT;
        w_update     = 1'b0;
        w_zero_write = 1'b0;

        unique case (i_kind)
            KIND_TICK: begin
                case (r_alert)
                    ALERT_CONT: begin
                        w_show = 1'b1;
                    end
                    ALERT_BLINK: begin
                        w_run_blink = 1'b1;
                    end
                    ALERT_FLASH: begin
                        w_run_blink = 1'b1;
                        w_step      = 2'd2;
                    end
                    ALERT_FADE: begin
                        n_count = (w_cnt > ON_LIMIT) ? '0 : r_count + COUNT_W'(1);
                        w_show  = 1'b1;
                    end
                    default: begin
                        case (r_mode)
                            MODE_BLINK: begin
                                w_run_blink = 1'b1;
                                w_idx       = ENT_BLINK;
                            end
                            MODE_IDLE: begin
                                w_show = 1'b1;
                                w_idx  = r_idle_sel ? ENT_FEEDBACK : ENT_IDLE;
                            end
                            MODE_TOUCH_SHORT: begin
                                w_show = 1'b1;
                                w_idx  = ENT_TOUCH_SHORT;
                            end
                            MODE_TOUCH_DOUBLE: begin
                                w_show = 1'b1;
                                w_idx  = ENT_TOUCH_DOUBLE;
                            end
                            MODE_TOUCH_LONG: begin
                                w_show = 1'b1;
                                w_idx  = ENT_TOUCH_LONG;
                            end
                            MODE_OFF: begin
                                w_update = r_enabled;
                            end
                            default: ;
                        endcase
                    end
                endcase
            end
            KIND_ENABLE: begin
                n_enabled = 1'b1;
                n_mode    = MODE_IDLE;
                w_update  = 1'b1;
            end
            KIND_DISABLE: begin
                n_enabled = 1'b0;
                n_mode    = MODE_OFF;
                o_written = WR_IMMEDIATE;
            end
            KIND_ON, KIND_OFF, KIND_INTENSITY, KIND_SHOW,
            KIND_SET_MODE, KIND_IDLE_SEL, KIND_ALERT: begin
                if (!r_enabled) begin
                    o_status = 1'b1;
                end else begin
                    case (i_kind)
                        KIND_ON: begin
                            n_mode   = MODE_IDLE;
                            w_update = 1'b1;
                        end
                        KIND_OFF: begin
                            n_mode   = MODE_OFF;
                            w_update = 1'b1;
                        end
                        KIND_INTENSITY: begin
                            n_intensity = i_value;
                            w_update    = 1'b1;
                        end
                        KIND_SHOW: begin
                            w_show       = 1'b1;
                            w_from_entry = 1'b0;
                        end
                        KIND_SET_MODE: begin
                            if (i_value <= MODE_MAX) begin
                                n_mode = t_mode'(i_value[2:0]);
                            end
                        end
                        KIND_IDLE_SEL: begin
                            n_idle_sel = |i_value;
                        end
                        default: begin
                            if (i_value <= ALERT_MAX) begin
                                n_alert = t_alert'(i_value[2:0]);
                            end
                        end
                    endcase
                end
            end
            default: ;
        endcase

        // Blink and flash: lit phase counts up, dark phase counts down.
        if (w_run_blink) begin
            if (w_blink_next > ON_LIMIT) begin
                n_count      = '1;
                w_zero_write = 1'b1;
            end else if (w_blink_next < OFF_LIMIT) begin
                n_count = '0;
                w_show  = 1'b1;
            end else begin
                n_count = w_blink_next[COUNT_W-1:0];
            end
        end

        // A colour change only lands while enabled, and then rewrites the duty.
        if (w_show && r_enabled) begin
            n_intensity = w_int;
            n_levels    = colour_levels(w_code);
            w_update    = 1'b1;
        end

        if (w_update || w_zero_write) begin
            o_written = WR_BUFFERED;
        end
    end

    // The multipliers see the updated colour; off mode, blanking and any result without a buffered write force zero.
    assign o_req.levels    = n_levels;
    assign o_req.intensity = n_intensity;
    assign o_req.zero      = (o_written != WR_BUFFERED) || w_zero_write || (n_mode == MODE_OFF);

endmodule

// ===== sv/rgb_status_led_controller_top.sv =====
// RGB status LED controller top level: input beat register, configuration
// entries, command logic, duty multipliers and the result register.
// Depends on rslc_pkg, rslc_core and rslc_duty.
// An accepted input beat passes through the input beat register and then the result register.
// Throughput: one item per cycle; the input register and the result register
// hand over in the same cycle, so only a stalled result register holds input.
// Reset (synchronous, active low) clears the valid flags, the configuration
// entries and all controller state; the block is disabled with the display off.
`timescale 1ns / 1ps

module rgb_status_led_controller_top import rslc_pkg::*; #(
    parameter int ON_TICKS  = ON_TICKS_DEF,
    parameter int OFF_TICKS = OFF_TICKS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write port
    input  logic                 i_cfg_we,
    input  logic [IDX_W-1:0]     i_cfg_index,
    input  logic [ENTRY_W-1:0]   i_cfg_data,
    // Input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // value [7:0], color [10:8], zero fill
    input  logic [KIND_W-1:0]    s_tuser,   // kind [3:0]
    // Result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [47:0]          m_tdata    // red_duty [13:0], green_duty [27:14],
                                            // blue_duty [41:28], duty_written [43:42],
                                            // status [44], zero fill
);

    logic                                r_in_valid;
    logic [KIND_W-1:0]                   r_in_kind;
    logic [VALUE_W-1:0]                  r_in_value;
    logic [CODE_W-1:0]                   r_in_color;
    logic [NUM_ENTRIES-1:0][ENTRY_W-1:0] r_entries;
    logic                                r_out_valid;
    logic [47:0]                         r_out_data;

    logic                                w_advance;
    t_duty_req                           w_req;
    t_written                            w_written;
    logic                                w_status;
    logic [DUTY_W-1:0]                   w_red;
    logic [DUTY_W-1:0]                   w_green;
    logic [DUTY_W-1:0]                   w_blue;

    // The input beat moves on whenever the result register is free or emptying.
    assign w_advance = r_in_valid && (!r_out_valid || m_tready);
    assign s_tready  = !r_in_valid || w_advance;

    // Input beat register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_in_kind  <= s_tuser;
            r_in_value <= s_tdata[VALUE_W-1:0];
            r_in_color <= s_tdata[VALUE_W+CODE_W-1:VALUE_W];
        end
    end

    // Configuration entries; indexes past the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries <= '0;
        end else if (i_cfg_we && (i_cfg_index < IDX_W'(NUM_ENTRIES))) begin
            r_entries[i_cfg_index] <= i_cfg_data;
        end
    end

    rslc_core #(
        .ON_TICKS  (ON_TICKS),
        .OFF_TICKS (OFF_TICKS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_kind    (r_in_kind),
        .i_value   (r_in_value),
        .i_color   (r_in_color),
        .i_entries (r_entries),
        .o_req     (w_req),
        .o_written (w_written),
        .o_status  (w_status)
    );

    rslc_duty u_duty (
        .i_req        (w_req),
        .o_red_duty   (w_red),
        .o_green_duty (w_green),
        .o_blue_duty  (w_blue)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_data <= {3'b000, w_status, w_written, w_blue, w_green, w_red};
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;

    // A rejected command never writes a duty.
    a_reject_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tdata[44]) |-> (m_tdata[43:42] == WR_NONE))
        else $error("rejected command carries a duty write");

    // Only a buffered write may carry non-zero duties.
    a_zero_unless_buffered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && (m_tdata[43:42] != WR_BUFFERED)) |-> (m_tdata[41:0] == '0))
        else $error("non-zero duty without a buffered write");

    // The write code is always one of the defined values.
    a_written_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> ((m_tdata[43:42] == WR_NONE) || (m_tdata[43:42] == WR_BUFFERED)
                      || (m_tdata[43:42] == WR_IMMEDIATE)))
        else $error("invalid duty write code");

    // Nothing is presented on the result side straight after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result valid after reset");

endmodule
